FILE: design/rac_pkg.sv
`timescale 1ns / 1ps
package rac_pkg;

  localparam int POS_W     = 37;
  localparam int VEL_W     = 25;
  localparam int PROD_W    = POS_W + VEL_W;
  localparam int MAG_W     = 62;
  localparam int HALF_W    = 31;
  localparam int VSQ_W     = 2 * VEL_W;
  localparam int SV_W      = VSQ_W + 2;
  localparam int SQ_STEPS  = 62;
  localparam int RAD_W     = 2 * SQ_STEPS;
  localparam int ROOT_W    = SQ_STEPS;
  localparam int REM_W     = ROOT_W + 4;
  localparam int Q_W       = 31;
  localparam int DIV_STEPS = Q_W;
  localparam int DREM_W    = ROOT_W + 1;
  localparam int ENT_W     = 32;
  localparam int LANES     = 6;
  localparam int IN_W      = 192;
  localparam int OUT_W     = 9 * ENT_W;

  localparam logic [ENT_W-1:0] Q_ONE = 32'h4000_0000;

  typedef struct packed {
    logic [LANES-1:0][MAG_W-1:0] mag;
    logic [LANES-1:0]            neg;
    logic                        deg;
  } comp_t;

endpackage

FILE: design/ecef_to_rac_rotation.sv
`timescale 1ns / 1ps
// ECEF to radial / along-track / cross-track rotation. Each transfer carries one
// satellite position (mm) and velocity (mm/s); the result carries the three rows
// of the rotation in Q2.30, rounded to nearest, plus a degenerate flag that is set
// (with all entries zero) when the velocity or position x velocity is zero. The
// block takes one item every clock cycle while the result side is not stalled, and
// each result passes through the 62-stage square root pipeline and the 32-stage quotient
// pipeline. A stall on the result side holds the whole pipeline.
module ecef_to_rac_rotation (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, zero pad
  input  logic [rac_pkg::IN_W-1:0]  in_tdata,
  output logic                      out_tvalid,
  input  logic                      out_tready,
  // radial_x, radial_y, radial_z, along_x, along_y, along_z, cross_x, cross_y, cross_z
  output logic [rac_pkg::OUT_W-1:0] out_tdata,
  // degenerate
  output logic                      out_tuser
);
  import rac_pkg::*;

  logic                       adv;
  logic [2:0][POS_W-1:0]      pos;
  logic [2:0][VEL_W-1:0]      vel;
  logic                       f_valid, s_valid, d_valid;
  logic [1:0][RAD_W-1:0]      f_rad;
  comp_t                      f_side, s_side;
  logic [1:0][ROOT_W-1:0]     s_root;
  logic [LANES-1:0][Q_W-1:0]  d_q;
  logic [LANES-1:0]           d_neg;
  logic                       d_deg;
  logic [8:0][ENT_W-1:0]      ent;

  assign adv       = !out_tvalid || out_tready;
  assign in_tready = adv;

  assign pos[0] = in_tdata[POS_W-1:0];
  assign pos[1] = in_tdata[2*POS_W-1:POS_W];
  assign pos[2] = in_tdata[3*POS_W-1:2*POS_W];
  assign vel[0] = in_tdata[3*POS_W+VEL_W-1:3*POS_W];
  assign vel[1] = in_tdata[3*POS_W+2*VEL_W-1:3*POS_W+VEL_W];
  assign vel[2] = in_tdata[3*POS_W+3*VEL_W-1:3*POS_W+2*VEL_W];

  rac_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_valid  (in_tvalid),
    .in_pos    (pos),
    .in_vel    (vel),
    .out_valid (f_valid),
    .out_rad   (f_rad),
    .out_side  (f_side)
  );

  rac_isqrt u_isqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_valid  (f_valid),
    .in_rad    (f_rad),
    .in_side   (f_side),
    .out_valid (s_valid),
    .out_root  (s_root),
    .out_side  (s_side)
  );

  rac_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_valid  (s_valid),
    .in_root   (s_root),
    .in_side   (s_side),
    .out_valid (d_valid),
    .out_q     (d_q),
    .out_neg   (d_neg),
    .out_deg   (d_deg)
  );

  rac_radial u_radial (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_valid  (d_valid),
    .in_q      (d_q),
    .in_neg    (d_neg),
    .in_deg    (d_deg),
    .out_valid (out_tvalid),
    .out_ent   (ent),
    .out_deg   (out_tuser)
  );

  assign out_tdata = ent;

endmodule

FILE: design/rac_front.sv
`timescale 1ns / 1ps
module rac_front (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   en,
  input  logic                                   in_valid,
  input  logic [2:0][rac_pkg::POS_W-1:0]         in_pos,
  input  logic [2:0][rac_pkg::VEL_W-1:0]         in_vel,
  output logic                                   out_valid,
  output logic [1:0][rac_pkg::RAD_W-1:0]         out_rad,
  output rac_pkg::comp_t                         out_side
);
  import rac_pkg::*;

  logic [4:0]                vld_r;
  logic signed [PROD_W-1:0]  pv_r [6];
  logic [VEL_W-1:0]          vm_r [3];
  logic [2:0]                vneg_r;
  comp_t                     side2_r, side3_r, side4_r, side5_r;
  logic [VSQ_W-1:0]          vsq_r [3];
  logic                      vzero2_r;
  logic [2*HALF_W-1:0]       hh_r [3], hl_r [3], ll_r [3];
  logic [SV_W-1:0]           sv3_r, sv4_r, sv5_r;
  logic [RAD_W-1:0]          csq_r [3];
  logic [RAD_W-1:0]          sc5_r;

  logic signed [PROD_W:0]    c_nxt [3];
  comp_t                     side2_nxt;
  comp_t                     side3_nxt;
  logic                      czero_nxt;

  always_comb begin
    side2_nxt = '0;
    for (int j = 0; j < 3; j++) begin
      c_nxt[j] = (PROD_W+1)'(pv_r[2*j]) - (PROD_W+1)'(pv_r[2*j+1]);
      side2_nxt.mag[j]   = MAG_W'(vm_r[j]);
      side2_nxt.neg[j]   = vneg_r[j];
      side2_nxt.neg[j+3] = c_nxt[j][PROD_W];
      side2_nxt.mag[j+3] = c_nxt[j][PROD_W] ? MAG_W'(-c_nxt[j]) : MAG_W'(c_nxt[j]);
    end
    czero_nxt = (side2_r.mag[3] == '0) && (side2_r.mag[4] == '0) && (side2_r.mag[5] == '0);
    side3_nxt     = side2_r;
    side3_nxt.deg = vzero2_r || czero_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[3:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // cross product terms
      pv_r[0] <= $signed(in_pos[1]) * $signed(in_vel[2]);
      pv_r[1] <= $signed(in_pos[2]) * $signed(in_vel[1]);
      pv_r[2] <= $signed(in_pos[2]) * $signed(in_vel[0]);
      pv_r[3] <= $signed(in_pos[0]) * $signed(in_vel[2]);
      pv_r[4] <= $signed(in_pos[0]) * $signed(in_vel[1]);
      pv_r[5] <= $signed(in_pos[1]) * $signed(in_vel[0]);
      for (int j = 0; j < 3; j++) begin
        vneg_r[j] <= in_vel[j][VEL_W-1];
        vm_r[j]   <= in_vel[j][VEL_W-1] ? -in_vel[j] : in_vel[j];
        vsq_r[j]  <= vm_r[j] * vm_r[j];
        hh_r[j]   <= side2_r.mag[j+3][MAG_W-1:HALF_W] * side2_r.mag[j+3][MAG_W-1:HALF_W];
        hl_r[j]   <= side2_r.mag[j+3][MAG_W-1:HALF_W] * side2_r.mag[j+3][HALF_W-1:0];
        ll_r[j]   <= side2_r.mag[j+3][HALF_W-1:0] * side2_r.mag[j+3][HALF_W-1:0];
        csq_r[j]  <= {hh_r[j], {(RAD_W-2*HALF_W){1'b0}}}
                   + {{(RAD_W-2*HALF_W-HALF_W-1){1'b0}}, hl_r[j], {(HALF_W+1){1'b0}}}
                   + {{(RAD_W-2*HALF_W){1'b0}}, ll_r[j]};
      end
      side2_r  <= side2_nxt;
      vzero2_r <= (vm_r[0] == '0) && (vm_r[1] == '0) && (vm_r[2] == '0);
      sv3_r    <= SV_W'(vsq_r[0]) + SV_W'(vsq_r[1]) + SV_W'(vsq_r[2]);
      side3_r  <= side3_nxt;
      sv4_r    <= sv3_r;
      side4_r  <= side3_r;
      sc5_r    <= csq_r[0] + csq_r[1] + csq_r[2];
      sv5_r    <= sv4_r;
      side5_r  <= side4_r;
    end
  end

  assign out_valid  = vld_r[4];
  assign out_rad[0] = RAD_W'(sv5_r);
  assign out_rad[1] = sc5_r;
  assign out_side   = side5_r;

endmodule

FILE: design/rac_isqrt.sv
`timescale 1ns / 1ps
module rac_isqrt (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   en,
  input  logic                                   in_valid,
  input  logic [1:0][rac_pkg::RAD_W-1:0]         in_rad,
  input  rac_pkg::comp_t                         in_side,
  output logic                                   out_valid,
  output logic [1:0][rac_pkg::ROOT_W-1:0]        out_root,
  output rac_pkg::comp_t                         out_side
);
  import rac_pkg::*;

  logic [SQ_STEPS-1:0]      vld_r;
  logic [1:0][RAD_W-1:0]    rad_r    [SQ_STEPS];
  logic [1:0][RAD_W-1:0]    rad_nxt  [SQ_STEPS];
  logic [1:0][REM_W-1:0]    rem_r    [SQ_STEPS];
  logic [1:0][REM_W-1:0]    rem_nxt  [SQ_STEPS];
  logic [1:0][ROOT_W-1:0]   root_r   [SQ_STEPS];
  logic [1:0][ROOT_W-1:0]   root_nxt [SQ_STEPS];
  comp_t                    side_r   [SQ_STEPS];

  // two radicand bits per stage, one root bit per stage
  always_comb begin
    logic [RAD_W-1:0]  s_rad;
    logic [REM_W-1:0]  s_rem;
    logic [ROOT_W-1:0] s_root;
    logic [REM_W-1:0]  t;
    logic [REM_W-1:0]  trial;
    for (int k = 0; k < SQ_STEPS; k++) begin
      for (int j = 0; j < 2; j++) begin
        if (k == 0) begin
          s_rad  = in_rad[j];
          s_rem  = '0;
          s_root = '0;
        end else begin
          s_rad  = rad_r[k-1][j];
          s_rem  = rem_r[k-1][j];
          s_root = root_r[k-1][j];
        end
        t     = {s_rem[REM_W-3:0], s_rad[RAD_W-1 -: 2]};
        trial = {{(REM_W-ROOT_W-2){1'b0}}, s_root, 2'b01};
        rad_nxt[k][j] = {s_rad[RAD_W-3:0], 2'b00};
        if (t >= trial) begin
          rem_nxt[k][j]  = t - trial;
          root_nxt[k][j] = {s_root[ROOT_W-2:0], 1'b1};
        end else begin
          rem_nxt[k][j]  = t;
          root_nxt[k][j] = {s_root[ROOT_W-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[SQ_STEPS-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < SQ_STEPS; k++) begin
        rad_r[k]  <= rad_nxt[k];
        rem_r[k]  <= rem_nxt[k];
        root_r[k] <= root_nxt[k];
        side_r[k] <= (k == 0) ? in_side : side_r[k == 0 ? 0 : k-1];
      end
    end
  end

  assign out_valid = vld_r[SQ_STEPS-1];
  assign out_root  = root_r[SQ_STEPS-1];
  assign out_side  = side_r[SQ_STEPS-1];

endmodule

FILE: design/rac_div.sv
`timescale 1ns / 1ps
module rac_div (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   en,
  input  logic                                   in_valid,
  input  logic [1:0][rac_pkg::ROOT_W-1:0]        in_root,
  input  rac_pkg::comp_t                         in_side,
  output logic                                   out_valid,
  output logic [rac_pkg::LANES-1:0][rac_pkg::Q_W-1:0] out_q,
  output logic [rac_pkg::LANES-1:0]              out_neg,
  output logic                                   out_deg
);
  import rac_pkg::*;

  localparam int STG = DIV_STEPS + 1;
  localparam int NUM_W = MAG_W + Q_W + 1;

  logic [STG-1:0]                   vld_r;
  logic [LANES-1:0][DREM_W-1:0]     rem_r  [STG];
  logic [LANES-1:0][DREM_W-1:0]     rem_nxt[STG];
  logic [LANES-1:0][Q_W-1:0]        low_r  [STG];
  logic [LANES-1:0][Q_W-1:0]        low_nxt[STG];
  logic [LANES-1:0][DREM_W-1:0]     dd_r   [STG];
  logic [LANES-1:0][DREM_W-1:0]     dd_nxt [STG];
  logic [LANES-1:0][Q_W-1:0]        q_r    [STG];
  logic [LANES-1:0][Q_W-1:0]        q_nxt  [STG];
  logic [LANES-1:0]                 neg_r  [STG];
  logic [STG-1:0]                   deg_r;

  // stage 0 forms (2|n|*2^30 + d) and 2d, then one quotient bit per stage
  always_comb begin
    logic [NUM_W-1:0]  num;
    logic [ROOT_W-1:0] d;
    logic [DREM_W:0]   t;
    for (int i = 0; i < LANES; i++) begin
      d   = (i < 3) ? in_root[0] : in_root[1];
      num = {1'b0, in_side.mag[i], {Q_W{1'b0}}} + NUM_W'(d);
      rem_nxt[0][i] = num[NUM_W-1:Q_W];
      low_nxt[0][i] = num[Q_W-1:0];
      dd_nxt[0][i]  = {d, 1'b0};
      q_nxt[0][i]   = '0;
      for (int k = 1; k < STG; k++) begin
        t = {rem_r[k-1][i], low_r[k-1][i][Q_W-1]};
        low_nxt[k][i] = {low_r[k-1][i][Q_W-2:0], 1'b0};
        dd_nxt[k][i]  = dd_r[k-1][i];
        if (t >= {1'b0, dd_r[k-1][i]}) begin
          rem_nxt[k][i] = DREM_W'(t - {1'b0, dd_r[k-1][i]});
          q_nxt[k][i]   = {q_r[k-1][i][Q_W-2:0], 1'b1};
        end else begin
          rem_nxt[k][i] = DREM_W'(t);
          q_nxt[k][i]   = {q_r[k-1][i][Q_W-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[STG-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < STG; k++) begin
        rem_r[k] <= rem_nxt[k];
        low_r[k] <= low_nxt[k];
        dd_r[k]  <= dd_nxt[k];
        q_r[k]   <= q_nxt[k];
      end
      neg_r[0] <= in_side.neg;
      for (int k = 1; k < STG; k++) begin
        neg_r[k] <= neg_r[k-1];
      end
      deg_r <= {deg_r[STG-2:0], in_side.deg};
    end
  end

  assign out_valid = vld_r[STG-1];
  assign out_q     = q_r[STG-1];
  assign out_neg   = neg_r[STG-1];
  assign out_deg   = deg_r[STG-1];

endmodule

FILE: design/rac_radial.sv
`timescale 1ns / 1ps
module rac_radial (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   en,
  input  logic                                   in_valid,
  input  logic [rac_pkg::LANES-1:0][rac_pkg::Q_W-1:0] in_q,
  input  logic [rac_pkg::LANES-1:0]              in_neg,
  input  logic                                   in_deg,
  output logic                                   out_valid,
  output logic [8:0][rac_pkg::ENT_W-1:0]         out_ent,
  output logic                                   out_deg
);
  import rac_pkg::*;

  localparam int P_W = 2 * ENT_W;
  localparam int T_W = P_W + 1;
  localparam int R_W = MAG_W + 1;

  logic [3:0]                      vld_r;
  logic [LANES-1:0][ENT_W-1:0]     e0_r, e1_r, e2_r, e3_r;
  logic [3:0]                      deg_r;
  logic signed [P_W-1:0]           p_r [6];
  logic [MAG_W-1:0]                tm_r [3];
  logic [2:0]                      tn_r;
  logic [2:0][ENT_W-1:0]           rad_r;

  logic signed [T_W-1:0]           t_nxt [3];
  logic [2:0][ENT_W-1:0]           rad_nxt;

  always_comb begin
    logic [R_W-1:0]   rnd;
    logic [ENT_W:0]   q;
    for (int j = 0; j < 3; j++) begin
      t_nxt[j] = T_W'(p_r[2*j]) - T_W'(p_r[2*j+1]);
      rnd = R_W'(tm_r[j]) + (R_W'(1) << 29);
      q   = rnd[R_W-1:30];
      if (q > {1'b0, Q_ONE}) begin
        q = {1'b0, Q_ONE};
      end
      rad_nxt[j] = tn_r[j] ? -q[ENT_W-1:0] : q[ENT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < LANES; i++) begin
        if (in_deg) begin
          e0_r[i] <= '0;
        end else begin
          e0_r[i] <= in_neg[i] ? -{1'b0, in_q[i]} : {1'b0, in_q[i]};
        end
      end
      // along in lanes 0..2, cross in lanes 3..5
      p_r[0] <= $signed(e0_r[1]) * $signed(e0_r[5]);
      p_r[1] <= $signed(e0_r[2]) * $signed(e0_r[4]);
      p_r[2] <= $signed(e0_r[2]) * $signed(e0_r[3]);
      p_r[3] <= $signed(e0_r[0]) * $signed(e0_r[5]);
      p_r[4] <= $signed(e0_r[0]) * $signed(e0_r[4]);
      p_r[5] <= $signed(e0_r[1]) * $signed(e0_r[3]);
      for (int j = 0; j < 3; j++) begin
        tn_r[j]  <= t_nxt[j][T_W-1];
        tm_r[j]  <= t_nxt[j][T_W-1] ? MAG_W'(-t_nxt[j]) : MAG_W'(t_nxt[j]);
      end
      rad_r <= rad_nxt;
      e1_r  <= e0_r;
      e2_r  <= e1_r;
      e3_r  <= e2_r;
      deg_r <= {deg_r[2:0], in_deg};
    end
  end

  assign out_valid = vld_r[3];
  assign out_ent   = {e3_r, rad_r};
  assign out_deg   = deg_r[3];

endmodule

FILE: design/rac_checker.sv
`timescale 1ns / 1ps
module rac_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_tready,
  input logic                      out_tvalid,
  input logic                      out_tready,
  input logic [rac_pkg::OUT_W-1:0] out_tdata,
  input logic                      out_tuser
);
  import rac_pkg::*;

  a_ready_follows_output: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready == (!out_tvalid || out_tready))
    else $error("input ready does not follow output stall");

  a_degenerate_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == '0)
    else $error("degenerate result with nonzero entries");

  a_along_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ($signed(out_tdata[4*ENT_W-1:3*ENT_W]) <= $signed(Q_ONE)
                    && $signed(out_tdata[4*ENT_W-1:3*ENT_W]) >= -$signed(Q_ONE)))
    else $error("along entry out of unit range");

  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

endmodule

bind ecef_to_rac_rotation rac_checker u_rac_checker (.*);

FILE: test/ecef_to_rac_rotation_test.sv
`timescale 1ns / 1ps
module ecef_to_rac_rotation_test;
  import rac_pkg::*;

  typedef struct {
    logic [OUT_W-1:0] rows;
    logic             deg;
  } rotation_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_tvalid = 1'b0;
  logic             in_tready;
  logic [IN_W-1:0]  in_tdata = '0;
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;
  logic             out_tuser;

  logic [IN_W-1:0] sat_states[$];
  rotation_t       rotations_due[$];
  int              n_sent = 0;
  int              n_errors = 0;
  int              send_gap = 0;
  int              recv_gap = 0;
  int              hold_cnt = 0;
  bit              hold_done = 1'b0;
  bit              quiet = 1'b0;
  int              idle_cycles = 0;

  ecef_to_rac_rotation u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  always #6 clk = ~clk;

  function automatic logic [63:0] abs64(longint x);
    return x < 0 ? 64'(-x) : 64'(x);
  endfunction

  function automatic logic [127:0] square(longint x);
    logic [127:0] w;
    w = abs64(x);
    return w * w;
  endfunction

  function automatic logic [63:0] floor_sqrt(logic [127:0] n);
    logic [63:0]  root;
    logic [63:0]  cand;
    logic [127:0] w;
    root = '0;
    for (int b = 63; b >= 0; b--) begin
      cand = root | (64'd1 << b);
      w = cand;
      if (w * w <= n) root = cand;
    end
    return root;
  endfunction

  function automatic longint unit_q30(longint n, logic [63:0] d);
    logic [127:0] num;
    logic [127:0] den;
    logic [127:0] q;
    num = (128'(abs64(n)) << 31) + 128'(d);
    den = 128'(d) << 1;
    q = num / den;
    return n < 0 ? -longint'(q[63:0]) : longint'(q[63:0]);
  endfunction

  function automatic longint cross_q30(longint a1, longint b2, longint a2, longint b1);
    longint      t;
    logic [63:0] q;
    t = a1 * b2 - a2 * b1;
    q = (abs64(t) + (64'd1 << 29)) >> 30;
    if (q > 64'(Q_ONE)) q = 64'(Q_ONE);
    return t < 0 ? -longint'(q) : longint'(q);
  endfunction

  function automatic rotation_t rotation_of(logic [IN_W-1:0] d);
    longint      p[3];
    longint      v[3];
    longint      c[3];
    longint      e[9];
    logic [127:0] sv;
    logic [127:0] sc;
    logic [63:0] nv;
    logic [63:0] nc;
    rotation_t   r;
    for (int i = 0; i < 3; i++) begin
      p[i] = $signed(d[i*POS_W +: POS_W]);
      v[i] = $signed(d[3*POS_W + i*VEL_W +: VEL_W]);
    end
    c[0] = p[1] * v[2] - p[2] * v[1];
    c[1] = p[2] * v[0] - p[0] * v[2];
    c[2] = p[0] * v[1] - p[1] * v[0];
    sv = square(v[0]) + square(v[1]) + square(v[2]);
    sc = square(c[0]) + square(c[1]) + square(c[2]);
    r.rows = '0;
    r.deg = 1'b0;
    if (sv == 0 || sc == 0) begin
      r.deg = 1'b1;
      return r;
    end
    nv = floor_sqrt(sv);
    nc = floor_sqrt(sc);
    for (int i = 0; i < 3; i++) begin
      e[3+i] = unit_q30(v[i], nv);
      e[6+i] = unit_q30(c[i], nc);
    end
    e[0] = cross_q30(e[4], e[8], e[5], e[7]);
    e[1] = cross_q30(e[5], e[6], e[3], e[8]);
    e[2] = cross_q30(e[3], e[7], e[4], e[6]);
    for (int i = 0; i < 9; i++) r.rows[i*ENT_W +: ENT_W] = e[i][ENT_W-1:0];
    return r;
  endfunction

  function automatic logic [IN_W-1:0] pack_state(longint px, longint py, longint pz,
                                                 longint vx, longint vy, longint vz);
    logic [IN_W-1:0] d;
    d = '0;
    d[0 +: POS_W] = px[POS_W-1:0];
    d[POS_W +: POS_W] = py[POS_W-1:0];
    d[2*POS_W +: POS_W] = pz[POS_W-1:0];
    d[3*POS_W +: VEL_W] = vx[VEL_W-1:0];
    d[3*POS_W + VEL_W +: VEL_W] = vy[VEL_W-1:0];
    d[3*POS_W + 2*VEL_W +: VEL_W] = vz[VEL_W-1:0];
    return d;
  endfunction

  // random signed value with a random bit length up to w
  function automatic longint rand_signed(int w);
    longint x;
    int     n;
    n = $urandom_range(1, w);
    x = longint'({$urandom, $urandom});
    x = x >>> (64 - n);
    return x;
  endfunction

  task automatic push_random(int count);
    longint k;
    longint v[3];
    for (int i = 0; i < count; i++) begin
      for (int j = 0; j < 3; j++) v[j] = rand_signed(VEL_W);
      case ($urandom_range(0, 9))
        0: begin
          k = rand_signed(12);
          sat_states.push_back(pack_state(k * v[0], k * v[1], k * v[2], v[0], v[1], v[2]));
        end
        1: sat_states.push_back(pack_state(rand_signed(POS_W), rand_signed(POS_W),
                                           rand_signed(POS_W), 0, 0, 0));
        2: sat_states.push_back(pack_state(rand_signed(POS_W), 0, 0, 0, rand_signed(VEL_W), 0));
        default:
          sat_states.push_back(pack_state(rand_signed(POS_W), rand_signed(POS_W),
                                          rand_signed(POS_W), v[0], v[1], v[2]));
      endcase
    end
  endtask

  initial begin
    longint pmax;
    longint pmin;
    longint vmax;
    longint vmin;
    pmax = 64'sd68719476735;
    pmin = -64'sd68719476736;
    vmax = 64'sd16777215;
    vmin = -64'sd16777216;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    sat_states.push_back(pack_state(pmax, pmax, pmax, vmax, vmax, vmin));
    sat_states.push_back(pack_state(pmin, pmin, pmin, vmin, vmax, vmax));
    sat_states.push_back(pack_state(pmax, pmin, 0, vmin, vmin, vmin));
    sat_states.push_back(pack_state(pmin, 0, 0, 0, vmin, 0));
    sat_states.push_back(pack_state(pmax, 0, 0, 0, 0, vmax));
    sat_states.push_back(pack_state(64'sd6378137000, 0, 0, 0, 7500000, 0));
    sat_states.push_back(pack_state(0, 0, 64'sd26560000000, 3900000, 0, 0));
    sat_states.push_back(pack_state(-1, -1, -1, -1, 1, 0));
    sat_states.push_back(pack_state(1, 0, 0, 1, 1, 1));
    sat_states.push_back(pack_state(3, 0, 0, 0, 1, 2));
    // zero velocity
    sat_states.push_back(pack_state(pmax, 5, -7, 0, 0, 0));
    // position parallel to velocity
    sat_states.push_back(pack_state(1000, -2000, 3000, 1, -2, 3));
    sat_states.push_back(pack_state(pmin, 0, 0, vmin, 0, 0));
    // zero position
    sat_states.push_back(pack_state(0, 0, 0, vmax, 12345, -9));
    sat_states.push_back(pack_state(0, 0, 0, 0, 0, 0));
    sat_states.push_back(pack_state(pmax, pmax, pmin, vmax, vmin, vmax));
    sat_states.push_back(pack_state(-5, 7, 11, vmin, vmin, vmax));
    wait (sat_states.size() == 0 && rotations_due.size() == 0);
    push_random(400);
    // sender pauses until the pipeline has drained
    wait (sat_states.size() == 0 && rotations_due.size() == 0);
    push_random(380);
    wait (sat_states.size() <= 100);
    quiet = 1'b1;
    wait (sat_states.size() == 0 && rotations_due.size() == 0);
    repeat (150) @(posedge clk);
    if (n_errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // driver
  always @(posedge clk) begin
    logic nxt_valid;
    if (rst_n) begin
      nxt_valid = in_tvalid;
      if (in_tvalid && in_tready) begin
        rotations_due.push_back(rotation_of(in_tdata));
        void'(sat_states.pop_front());
        n_sent++;
        nxt_valid = 1'b0;
      end
      if (!nxt_valid) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (sat_states.size() > 0) begin
          if (!quiet && $urandom_range(0, 7) == 0) begin
            send_gap = $urandom_range(1, 6) - 1;
          end else begin
            nxt_valid = 1'b1;
            in_tdata <= sat_states[0];
          end
        end
      end
      in_tvalid <= nxt_valid;
    end
  end

  // monitor
  always @(posedge clk) begin
    rotation_t want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (rotations_due.size() == 0) begin
          n_errors++;
          if (n_errors <= 10) $display("unexpected result transfer %h", out_tdata);
        end else begin
          want = rotations_due.pop_front();
          for (int i = 0; i < 9; i++) begin
            if (out_tdata[i*ENT_W +: ENT_W] !== want.rows[i*ENT_W +: ENT_W]) begin
              n_errors++;
              if (n_errors <= 10)
                $display("entry %0d mismatch: expected %h, got %h", i,
                         want.rows[i*ENT_W +: ENT_W], out_tdata[i*ENT_W +: ENT_W]);
            end
          end
          if (out_tuser !== want.deg) begin
            n_errors++;
            if (n_errors <= 10)
              $display("degenerate mismatch: expected %b, got %b", want.deg, out_tuser);
          end
        end
      end
      // long hold-off so the pipeline fills and stalls its input
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_tready <= 1'b0;
      end else if (!hold_done && n_sent >= 450) begin
        hold_done = 1'b1;
        hold_cnt = 400;
        out_tready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        out_tready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        recv_gap = $urandom_range(1, 6) - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
          (sat_states.size() == 0 && rotations_due.size() == 0)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= 3000) begin
        $display("CHECK FAILED");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

endmodule
